// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Simulation builds get the property check; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFKH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFKH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SFKH_ASSERT(label, clk, rst_n, prop, msg)
`define SFKH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/sfkh_pkg.sv
`default_nettype none

package sfkh_pkg;

  // Q1.16 unity and covariance reset value
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Shared divider geometry: quotient always fits QUO_W bits
  localparam int unsigned DIV_NUM_W = 36;
  localparam int unsigned DIV_DEN_W = 18;
  localparam int unsigned DIV_QUO_W = 17;

  // Configuration register reset values
  localparam logic [15:0] WEIGHT_A_RST  = 16'd26214;
  localparam logic [15:0] WEIGHT_B_RST  = 16'd19661;
  localparam logic [15:0] WEIGHT_C_RST  = 16'd19661;
  localparam logic [15:0] MEAS_NOISE_RST = 16'd13107;
  localparam logic [15:0] TARGET_RST    = 16'd15360;
  localparam logic [14:0] BAND_RST      = 15'd512;

  typedef enum logic [2:0] {
    REG_WEIGHT_A   = 3'd0,
    REG_WEIGHT_B   = 3'd1,
    REG_WEIGHT_C   = 3'd2,
    REG_MEAS_NOISE = 3'd3,
    REG_TARGET     = 3'd4,
    REG_HYST_BAND  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ACC,
    ST_FDIV_GO,
    ST_FDIV_RUN,
    ST_KDIV_GO,
    ST_KDIV_RUN,
    ST_KMUL,
    ST_UPD_EST,
    ST_UPD_COV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/fused_scalar_kalman_hysteresis_top.sv
`default_nettype none
`include "assert_macros.svh"

// Channel   Handshake                 Payload
// --------  ------------------------  ---------------------------------------------------
// cfg       cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
// in        in_valid_i / in_ready_o   reading_a/b/c_i, first_of_group_i, last_of_group_i
// out       out_valid_o / out_ready_i fused_value_o, filtered_estimate_o, kalman_gain_o,
//                                     pump_on_o, group_done_o, weight_error_o
//
// Each item runs through the sequencer from acceptance until its result is loaded; each of the
// two divisions is skipped when its divisor is zero (zero weight sum, zero P plus R).
// The shared restoring divider yields one quotient bit per cycle while busy and is used
// once for the weighted average and once for the gain; one multiplier makes five passes.
// Reset restores all configuration registers, clears the estimate, sets P to 1.0 and
// turns the pump off. A stalled output holds its result; the next item may be accepted
// meanwhile and waits in the final state until the output register frees up.
module fused_scalar_kalman_hysteresis_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic        [2:0]  cfg_idx_i,
  input  wire logic        [15:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] reading_a_i,
  input  wire logic signed [15:0] reading_b_i,
  input  wire logic signed [15:0] reading_c_i,
  input  wire logic               first_of_group_i,
  input  wire logic               last_of_group_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [15:0] fused_value_o,
  output logic signed      [15:0] filtered_estimate_o,
  output logic             [16:0] kalman_gain_o,
  output logic                    pump_on_o,
  output logic                    group_done_o,
  output logic                    weight_error_o
);

  localparam int unsigned NW = sfkh_pkg::DIV_NUM_W;
  localparam int unsigned DW = sfkh_pkg::DIV_DEN_W;
  localparam int unsigned QW = sfkh_pkg::DIV_QUO_W;

  // Configuration registers
  logic [15:0] weight_a_q, weight_b_q, weight_c_q, meas_noise_q, target_q;
  logic [14:0] band_q;

  // Filter state
  logic [15:0] est_q;
  logic [16:0] cov_q;
  logic        pump_q;

  // Item working registers
  logic [15:0] rd_a_q, rd_b_q, rd_c_q;
  logic        last_q;
  logic [17:0] wsum_q;
  logic [34:0] acc_q;
  logic [35:0] prod_q;
  logic [15:0] fused_q;
  logic        werr_q;
  logic [16:0] gain_q;

  // Output register
  logic        out_valid_q;
  logic [15:0] out_fused_q, out_est_q;
  logic [16:0] out_gain_q;
  logic        out_pump_q, out_done_q, out_werr_q;

  sfkh_pkg::state_e state_q, state_d;

  // Shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;

  // Divider hookup
  logic                div_start;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic [QW-1:0]       div_quo;
  sfkh_pkg::div_stat_t div_stat;

  logic        in_fire;
  logic        out_free;
  logic [34:0] acc_mag;
  logic [17:0] kal_den;
  logic [16:0] est_diff;
  logic [15:0] fused_div;
  logic        prod_neg;
  logic [35:0] prod_mag;
  logic [35:0] prod_rnd;
  logic [20:0] est_sum;
  logic [15:0] est_new;
  logic [35:0] cov_rnd;
  logic [16:0] band_lo, band_hi;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Config writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_a_q   <= sfkh_pkg::WEIGHT_A_RST;
      weight_b_q   <= sfkh_pkg::WEIGHT_B_RST;
      weight_c_q   <= sfkh_pkg::WEIGHT_C_RST;
      meas_noise_q <= sfkh_pkg::MEAS_NOISE_RST;
      target_q     <= sfkh_pkg::TARGET_RST;
      band_q       <= sfkh_pkg::BAND_RST;
    end else if (cfg_we_i) begin
      case (sfkh_pkg::cfg_idx_e'(cfg_idx_i))
        sfkh_pkg::REG_WEIGHT_A:   weight_a_q   <= cfg_data_i;
        sfkh_pkg::REG_WEIGHT_B:   weight_b_q   <= cfg_data_i;
        sfkh_pkg::REG_WEIGHT_C:   weight_c_q   <= cfg_data_i;
        sfkh_pkg::REG_MEAS_NOISE: meas_noise_q <= cfg_data_i;
        sfkh_pkg::REG_TARGET:     target_q     <= cfg_data_i;
        sfkh_pkg::REG_HYST_BAND:  band_q       <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Datapath values used by the sequencer
  always_comb begin
    acc_mag  = acc_q[34] ? (~acc_q + 35'd1) : acc_q;
    kal_den  = {1'b0, cov_q} + {2'b0, meas_noise_q};
    est_diff = {fused_q[15], fused_q} - {est_q[15], est_q};

    // Quotient is at most 32768; the positive side saturates
    if (acc_q[34]) begin
      fused_div = 16'(17'd0 - div_quo);
    end else if (div_quo > 17'd32767) begin
      fused_div = 16'h7fff;
    end else begin
      fused_div = div_quo[15:0];
    end

    // Round K*diff / 2**16 to nearest, ties away from zero
    prod_neg = prod_q[35];
    prod_mag = prod_neg ? (~prod_q + 36'd1) : prod_q;
    prod_rnd = prod_mag + 36'd32768;
    est_sum  = {{5{est_q[15]}}, est_q}
             + (prod_neg ? (21'd0 - {1'b0, prod_rnd[35:16]}) : {1'b0, prod_rnd[35:16]});
    if ($signed(est_sum) > 21'sd32767) begin
      est_new = 16'h7fff;
    end else if ($signed(est_sum) < -21'sd32768) begin
      est_new = 16'h8000;
    end else begin
      est_new = est_sum[15:0];
    end

    cov_rnd = prod_q + 36'd32768;
    band_lo = {target_q[15], target_q} - {2'b0, band_q};
    band_hi = {target_q[15], target_q} + {2'b0, band_q};
  end

  // Operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      sfkh_pkg::ST_MUL_A: begin
        mul_a = {{2{rd_a_q[15]}}, rd_a_q};
        mul_b = {2'b0, weight_a_q};
      end
      sfkh_pkg::ST_MUL_B: begin
        mul_a = {{2{rd_b_q[15]}}, rd_b_q};
        mul_b = {2'b0, weight_b_q};
      end
      sfkh_pkg::ST_MUL_C: begin
        mul_a = {{2{rd_c_q[15]}}, rd_c_q};
        mul_b = {2'b0, weight_c_q};
      end
      sfkh_pkg::ST_KMUL: begin
        mul_a = {est_diff[16], est_diff};
        mul_b = {1'b0, gain_q};
      end
      sfkh_pkg::ST_UPD_EST: begin
        mul_a = {1'b0, sfkh_pkg::ONE_Q16 - gain_q};
        mul_b = {1'b0, cov_q};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sequencer: next state and strobes
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    div_num    = NW'(acc_mag) + NW'(wsum_q >> 1);
    div_den    = wsum_q;
    case (state_q)
      sfkh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = sfkh_pkg::ST_MUL_A;
      end
      sfkh_pkg::ST_MUL_A: state_d = sfkh_pkg::ST_MUL_B;
      sfkh_pkg::ST_MUL_B: state_d = sfkh_pkg::ST_MUL_C;
      sfkh_pkg::ST_MUL_C: state_d = sfkh_pkg::ST_ACC;
      sfkh_pkg::ST_ACC:   state_d = sfkh_pkg::ST_FDIV_GO;
      sfkh_pkg::ST_FDIV_GO: begin
        if (wsum_q == '0) begin
          state_d = sfkh_pkg::ST_KDIV_GO;
        end else begin
          div_start = 1'b1;
          state_d   = sfkh_pkg::ST_FDIV_RUN;
        end
      end
      sfkh_pkg::ST_FDIV_RUN: begin
        if (div_stat.done) state_d = sfkh_pkg::ST_KDIV_GO;
      end
      sfkh_pkg::ST_KDIV_GO: begin
        div_num = NW'({cov_q, 16'd0}) + NW'(kal_den >> 1);
        div_den = kal_den;
        if (kal_den == '0) begin
          state_d = sfkh_pkg::ST_KMUL;
        end else begin
          div_start = 1'b1;
          state_d   = sfkh_pkg::ST_KDIV_RUN;
        end
      end
      sfkh_pkg::ST_KDIV_RUN: begin
        if (div_stat.done) state_d = sfkh_pkg::ST_KMUL;
      end
      sfkh_pkg::ST_KMUL:    state_d = sfkh_pkg::ST_UPD_EST;
      sfkh_pkg::ST_UPD_EST: state_d = sfkh_pkg::ST_UPD_COV;
      sfkh_pkg::ST_UPD_COV: state_d = sfkh_pkg::ST_DONE;
      sfkh_pkg::ST_DONE: begin
        if (out_free) state_d = sfkh_pkg::ST_IDLE;
      end
      default: state_d = sfkh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfkh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Filter state: restart on a first item, update in the closing states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= '0;
      cov_q  <= sfkh_pkg::ONE_Q16;
      pump_q <= 1'b0;
    end else begin
      if (in_fire && first_of_group_i) begin
        est_q <= '0;
        cov_q <= sfkh_pkg::ONE_Q16;
      end
      if (state_q == sfkh_pkg::ST_UPD_EST) begin
        est_q <= est_new;
      end
      if (state_q == sfkh_pkg::ST_UPD_COV) begin
        cov_q <= cov_rnd[32:16];
        // Dead band: below turns on, above turns off, inside holds
        if (last_q) begin
          if ($signed({est_q[15], est_q}) < $signed(band_lo)) begin
            pump_q <= 1'b1;
          end else if ($signed({est_q[15], est_q}) > $signed(band_hi)) begin
            pump_q <= 1'b0;
          end
        end
      end
    end
  end

  // Item working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      sfkh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          rd_a_q <= reading_a_i;
          rd_b_q <= reading_b_i;
          rd_c_q <= reading_c_i;
          last_q <= last_of_group_i;
          wsum_q <= {2'b0, weight_a_q} + {2'b0, weight_b_q} + {2'b0, weight_c_q};
        end
      end
      sfkh_pkg::ST_MUL_A: begin
        acc_q  <= '0;
        prod_q <= mul_p;
      end
      sfkh_pkg::ST_MUL_B, sfkh_pkg::ST_MUL_C: begin
        acc_q  <= acc_q + prod_q[34:0];
        prod_q <= mul_p;
      end
      sfkh_pkg::ST_ACC: acc_q <= acc_q + prod_q[34:0];
      sfkh_pkg::ST_FDIV_GO: begin
        // Zero weight sum: measurement forced to zero and flagged
        werr_q <= (wsum_q == '0);
        if (wsum_q == '0) fused_q <= '0;
      end
      sfkh_pkg::ST_FDIV_RUN: begin
        if (div_stat.done) fused_q <= fused_div;
      end
      sfkh_pkg::ST_KDIV_GO: begin
        if (kal_den == '0) gain_q <= '0;
      end
      sfkh_pkg::ST_KDIV_RUN: begin
        if (div_stat.done) begin
          gain_q <= (div_quo > sfkh_pkg::ONE_Q16) ? sfkh_pkg::ONE_Q16 : div_quo;
        end
      end
      sfkh_pkg::ST_KMUL, sfkh_pkg::ST_UPD_EST: prod_q <= mul_p;
      default: ;
    endcase
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == sfkh_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sfkh_pkg::ST_DONE && out_free) begin
      out_fused_q <= fused_q;
      out_est_q   <= est_q;
      out_gain_q  <= gain_q;
      out_pump_q  <= pump_q;
      out_done_q  <= last_q;
      out_werr_q  <= werr_q;
    end
  end

  sfkh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (div_quo),
    .stat_o (div_stat)
  );

  assign out_valid_o         = out_valid_q;
  assign fused_value_o       = out_fused_q;
  assign filtered_estimate_o = out_est_q;
  assign kalman_gain_o       = out_gain_q;
  assign pump_on_o           = out_pump_q;
  assign group_done_o        = out_done_q;
  assign weight_error_o      = out_werr_q;

  // Covariance never exceeds 1.0
  `SFKH_ASSERT(a_cov_range, clk_i, rst_ni, cov_q <= sfkh_pkg::ONE_Q16, "covariance above 1.0")
  // Reported gain never exceeds 1.0
  `SFKH_ASSERT_IMPL(a_gain_range, clk_i, rst_ni, out_valid_q, out_gain_q <= sfkh_pkg::ONE_Q16, "gain above 1.0")
  // Divider only runs while the sequencer waits on it
  `SFKH_ASSERT_IMPL(a_div_owner, clk_i, rst_ni, div_stat.busy, state_q == sfkh_pkg::ST_FDIV_RUN || state_q == sfkh_pkg::ST_KDIV_RUN, "divider busy outside a divide state")
  // A zero weight sum always reports a zero fused value
  `SFKH_ASSERT_IMPL(a_werr_zero, clk_i, rst_ni, out_valid_q && out_werr_q, out_fused_q == '0, "weight error with nonzero fused value")

endmodule

`default_nettype wire

// File: hw/rtl/sfkh_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Caller guarantees num < den * 2**DIV_QUO_W.
module sfkh_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [sfkh_pkg::DIV_NUM_W-1:0]       num_i,
  input  wire logic [sfkh_pkg::DIV_DEN_W-1:0]       den_i,
  output logic      [sfkh_pkg::DIV_QUO_W-1:0]       quo_o,
  output sfkh_pkg::div_stat_t                       stat_o
);

  localparam int unsigned NW = sfkh_pkg::DIV_NUM_W;
  localparam int unsigned QW = sfkh_pkg::DIV_QUO_W;
  localparam int unsigned SW = sfkh_pkg::DIV_DEN_W + QW - 1;
  localparam int unsigned CW = $clog2(QW);

  logic [NW-1:0] rem_q;
  logic [SW-1:0] dsh_q;
  logic [QW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic          fits;

  assign fits = rem_q >= NW'(dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(QW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, (QW - 1)'(0)};
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - NW'(dsh_q);
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire
